>>> rtl/lcgrng_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lcgrng_pkg;

	localparam int WORD_W   = 32;
	localparam int RESULT_W = 31;
	localparam int INDEX_W  = 6;
	localparam int LENGTH_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;
	localparam int MAX_TABLE_WORDS = 64;

	localparam logic [WORD_W-1:0] LCG_MULT = 32'd1103515245;
	localparam logic [WORD_W-1:0] LCG_INC  = 32'd12345;
	localparam logic [WORD_W-1:0] LOW31_MASK = 32'h7FFF_FFFF;

	localparam logic CMD_GENERATE = 1'b0;
	localparam logic CMD_LOAD     = 1'b1;

	localparam logic MODE_LCG      = 1'b0;
	localparam logic MODE_ADDITIVE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEPARATION = 2'd2;

	localparam logic [LENGTH_W-1:0] LENGTH_MIN   = 7'd2;
	localparam logic [LENGTH_W-1:0] LENGTH_RESET = 7'd31;
	localparam logic [INDEX_W-1:0]  SEP_RESET    = 6'd3;
	localparam logic [INDEX_W-1:0]  FRONT_RESET  = 6'd3;
	localparam logic [INDEX_W-1:0]  BACK_RESET   = 6'd0;
	localparam int INDEX_SPAN = 64;

endpackage
`default_nettype wire

>>> rtl/lcg_or_additive_random_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_stall   cmd, word_index, word_value
// out       source     out_valid / out_stall random_value
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction per cycle while the output is not stalled; a result goes from its input
// transaction through the read-stage registers into the result register. The word table is
// one memory with two registered read ports and one write port; the write of an item
// lands at the edge the next item reads, and a forwarding path covers that overlap.
// No clearing pass after reset: table words are valid only once loaded. A stalled
// output holds the result register and, with a generate in the read stage, stalls input.
module lcg_or_additive_random_generator (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 cmd,
	input  wire logic [lcgrng_pkg::INDEX_W-1:0]       word_index,
	input  wire logic [lcgrng_pkg::WORD_W-1:0]        word_value,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [lcgrng_pkg::RESULT_W-1:0]           random_value,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [lcgrng_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [lcgrng_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int AW = $clog2(lcgrng_pkg::MAX_TABLE_WORDS);
	localparam int LEN_CAP_I = (lcgrng_pkg::MAX_TABLE_WORDS < 127) ?
		lcgrng_pkg::MAX_TABLE_WORDS : 127;
	localparam logic [lcgrng_pkg::LENGTH_W-1:0] LEN_CAP = lcgrng_pkg::LENGTH_W'(LEN_CAP_I);

	logic                               mode_q;
	logic [lcgrng_pkg::LENGTH_W-1:0]    length_q;
	logic [lcgrng_pkg::INDEX_W-1:0]     sep_q;
	logic [lcgrng_pkg::INDEX_W-1:0]     front_q;
	logic [lcgrng_pkg::INDEX_W-1:0]     back_q;

	logic [AW-1:0] slot_tab [lcgrng_pkg::INDEX_SPAN];

	logic [lcgrng_pkg::WORD_W-1:0] mem [lcgrng_pkg::MAX_TABLE_WORDS];

	logic                               s1_valid;
	logic                               cmd_s1;
	logic                               mode_s1;
	logic [AW-1:0]                      wr_addr_s1;
	logic [lcgrng_pkg::WORD_W-1:0]      wval_s1;
	logic [lcgrng_pkg::WORD_W-1:0]      rdf_s1;
	logic [lcgrng_pkg::WORD_W-1:0]      rdb_s1;
	logic                               fwd_f_s1;
	logic                               fwd_b_s1;
	logic [lcgrng_pkg::WORD_W-1:0]      fwd_data_s1;

	logic                               out_valid_q;
	logic [lcgrng_pkg::RESULT_W-1:0]    random_value_q;

	logic                               in_acc;
	logic                               s1_go;
	logic                               wr_en;
	logic [lcgrng_pkg::WORD_W-1:0]      wr_data;
	logic [AW-1:0]                      addr_f;
	logic [AW-1:0]                      addr_b;
	logic [AW-1:0]                      addr_w;
	logic [lcgrng_pkg::LENGTH_W-1:0]    ring_len;
	logic [lcgrng_pkg::LENGTH_W-1:0]    front_inc;
	logic [lcgrng_pkg::LENGTH_W-1:0]    back_inc;
	logic [lcgrng_pkg::WORD_W-1:0]      front_word;
	logic [lcgrng_pkg::WORD_W-1:0]      back_word;
	logic [lcgrng_pkg::WORD_W-1:0]      new_word;

	for (genvar g = 0; g < lcgrng_pkg::INDEX_SPAN; g++) begin : g_slot
		localparam logic [AW-1:0] SLOT = AW'(g % lcgrng_pkg::MAX_TABLE_WORDS);
		assign slot_tab[g] = SLOT;
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= lcgrng_pkg::MODE_LCG;
			length_q <= lcgrng_pkg::LENGTH_RESET;
			sep_q    <= lcgrng_pkg::SEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lcgrng_pkg::CFG_MODE:       mode_q   <= cfg_data[0];
				lcgrng_pkg::CFG_LENGTH:     length_q <= cfg_data;
				lcgrng_pkg::CFG_SEPARATION: sep_q    <= cfg_data[lcgrng_pkg::INDEX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (length_q < lcgrng_pkg::LENGTH_MIN) begin
			ring_len = lcgrng_pkg::LENGTH_MIN;
		end else if (length_q > LEN_CAP) begin
			ring_len = LEN_CAP;
		end else begin
			ring_len = length_q;
		end
	end

	assign front_inc = {1'b0, front_q} + lcgrng_pkg::LENGTH_W'(1);
	assign back_inc  = {1'b0, back_q} + lcgrng_pkg::LENGTH_W'(1);

	assign s1_go    = !s1_valid || (cmd_s1 == lcgrng_pkg::CMD_LOAD) || !out_valid_q || !out_stall;
	assign in_stall = s1_valid && !s1_go;
	assign in_acc   = in_valid && !in_stall;

	assign addr_f = (mode_q == lcgrng_pkg::MODE_LCG) ? AW'(0) : slot_tab[front_q];
	assign addr_b = slot_tab[back_q];
	assign addr_w = (cmd == lcgrng_pkg::CMD_LOAD) ? slot_tab[word_index] : addr_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= lcgrng_pkg::FRONT_RESET;
			back_q  <= lcgrng_pkg::BACK_RESET;
		end else if (in_acc) begin
			if (cmd == lcgrng_pkg::CMD_LOAD) begin
				front_q <= sep_q;
				back_q  <= lcgrng_pkg::BACK_RESET;
			end else if (mode_q == lcgrng_pkg::MODE_ADDITIVE) begin
				front_q <= (front_inc >= ring_len) ? '0 : front_inc[lcgrng_pkg::INDEX_W-1:0];
				back_q  <= (back_inc >= ring_len) ? '0 : back_inc[lcgrng_pkg::INDEX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr_s1] <= wr_data;
		end
		if (in_acc) begin
			rdf_s1 <= mem[addr_f];
			rdb_s1 <= mem[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			fwd_f_s1 <= 1'b0;
			fwd_b_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_valid <= 1'b1;
				fwd_f_s1 <= wr_en && (wr_addr_s1 == addr_f);
				fwd_b_s1 <= wr_en && (wr_addr_s1 == addr_b);
			end else if (s1_go) begin
				s1_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1      <= cmd;
			mode_s1     <= mode_q;
			wr_addr_s1  <= addr_w;
			wval_s1     <= word_value;
			fwd_data_s1 <= wr_data;
		end
	end

	assign front_word = fwd_f_s1 ? fwd_data_s1 : rdf_s1;
	assign back_word  = fwd_b_s1 ? fwd_data_s1 : rdb_s1;

	always_comb begin
		if (mode_s1 == lcgrng_pkg::MODE_LCG) begin
			new_word = (front_word * lcgrng_pkg::LCG_MULT + lcgrng_pkg::LCG_INC)
				& lcgrng_pkg::LOW31_MASK;
		end else begin
			new_word = front_word + back_word;
		end
	end

	assign wr_en   = s1_valid && s1_go;
	assign wr_data = (cmd_s1 == lcgrng_pkg::CMD_LOAD) ? wval_s1 : new_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_en && (cmd_s1 == lcgrng_pkg::CMD_GENERATE)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (cmd_s1 == lcgrng_pkg::CMD_GENERATE)) begin
			if (mode_s1 == lcgrng_pkg::MODE_LCG) begin
				random_value_q <= new_word[lcgrng_pkg::RESULT_W-1:0];
			end else begin
				random_value_q <= new_word[lcgrng_pkg::WORD_W-1:1];
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign random_value = random_value_q;

endmodule
`default_nettype wire
